/* sv/hmsct_pkg.sv */
// hmsct_pkg: shared types and constants for the hh:mm:ss countdown timer.
// Used by the step logic, the top level and the testbench.
// No dependencies.
package hmsct_pkg;

    // Operation codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_TOGGLE = 3'd1;
    localparam logic [2:0] OP_RAISE  = 3'd2;
    localparam logic [2:0] OP_LOWER  = 3'd3;
    localparam logic [2:0] OP_COMMIT = 3'd4;

    // Preset field selects
    localparam logic [1:0] SEL_HOURS   = 2'd0;
    localparam logic [1:0] SEL_MINUTES = 2'd1;
    localparam logic [1:0] SEL_SECONDS = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TICK_STEP = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    localparam int CFG_DATA_W = 16;

    // Limits and reset values
    localparam logic [5:0]  HOUR_MAX       = 6'd23;
    localparam logic [5:0]  MINSEC_MAX     = 6'd59;
    localparam logic [9:0]  TICK_STEP_RST  = 10'd40;
    localparam logic [15:0] THRESHOLD_RST  = 16'd1000;

    typedef struct packed {
        logic [16:0] elapsed_ms;
        logic        run_flag;
        logic [4:0]  cur_hours;
        logic [5:0]  cur_minutes;
        logic [5:0]  cur_seconds;
        logic [4:0]  preset_hours;
        logic [5:0]  preset_minutes;
        logic [5:0]  preset_seconds;
    } timer_state_t;

    typedef struct packed {
        logic [4:0] count_hours;
        logic [5:0] count_minutes;
        logic [5:0] count_seconds;
        logic       is_running;
        logic       finished;
        logic [5:0] preset_value;
    } timer_result_t;

    typedef struct packed {
        logic [9:0]  tick_step_ms;
        logic [15:0] second_threshold_ms;
    } timer_cfg_t;

endpackage

/* sv/hmsct_in_if.sv */
// hmsct_in_if: command channel of the countdown timer (valid/ready + payload).
// Depends on nothing.
interface hmsct_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [1:0] field_select;

    modport source (output valid, output operation, output field_select, input ready);
    modport sink   (input valid, input operation, input field_select, output ready);
endinterface

/* sv/hmsct_out_if.sv */
// hmsct_out_if: result channel of the countdown timer (valid/ready + payload).
// Depends on nothing.
interface hmsct_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] count_hours;
    logic [5:0] count_minutes;
    logic [5:0] count_seconds;
    logic       is_running;
    logic       finished;
    logic [5:0] preset_value;

    modport source (
        output valid, output count_hours, output count_minutes, output count_seconds,
        output is_running, output finished, output preset_value, input ready
    );
    modport sink (
        input valid, input count_hours, input count_minutes, input count_seconds,
        input is_running, input finished, input preset_value, output ready
    );
endinterface

/* sv/hms_countdown_timer.sv */
// hms_countdown_timer: top level of the hh:mm:ss countdown timer with presets.
// Depends on hmsct_pkg, hmsct_in_if, hmsct_out_if and hmsct_step.
//
//  Channel   Dir  Handshake          Payload
//  -------   ---  ---------          -------
//  in_ch     in   valid/ready        operation, field_select
//  out_ch    out  valid/ready        count_hours/minutes/seconds, is_running,
//                                    finished, preset_value
//  cfg       in   cfg_we (no ready)  cfg_index, cfg_data
//
// For each command the step logic updates the timer state and loads the result
// register at the transfer edge; the result shows the next cycle.
// While out_ch.ready is high one command per cycle is sustained; the single result register sets this.
// in_ch.ready stays high while the result register is empty or being drained,
// so a new command enters in the same cycle a waiting result is taken.
// Reset clears the timer state and result valid and loads the default step (40)
// and threshold (1000); configuration writes take effect at the next edge.
module hms_countdown_timer
    import hmsct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    hmsct_in_if.sink              in_ch,
    hmsct_out_if.source           out_ch,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    timer_state_t  state_reg;
    timer_state_t  state_next;
    timer_cfg_t    cfg_reg;
    timer_result_t result_reg;
    timer_result_t result_next;
    logic          out_valid_reg;
    logic          in_xfer;

    // Accept whenever the result slot is free or draining this cycle.
    assign in_ch.ready = ~out_valid_reg | out_ch.ready;
    assign in_xfer     = in_ch.valid & in_ch.ready;

    hmsct_step u_step (
        .state        (state_reg),
        .cfg          (cfg_reg),
        .operation    (in_ch.operation),
        .field_select (in_ch.field_select),
        .state_next   (state_next),
        .result       (result_next)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_step_ms        <= TICK_STEP_RST;
            cfg_reg.second_threshold_ms <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TICK_STEP: cfg_reg.tick_step_ms        <= cfg_data[9:0];
                CFG_THRESHOLD: cfg_reg.second_threshold_ms <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Timer state: advance only on a command transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Result valid: set on a command transfer, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: hold while stalled, load on transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.count_hours   = result_reg.count_hours;
    assign out_ch.count_minutes = result_reg.count_minutes;
    assign out_ch.count_seconds = result_reg.count_seconds;
    assign out_ch.is_running    = result_reg.is_running;
    assign out_ch.finished      = result_reg.finished;
    assign out_ch.preset_value  = result_reg.preset_value;

endmodule

/* sv/hmsct_step.sv */
// hmsct_step: next-state and result logic for one timer command.
// Depends on hmsct_pkg.
module hmsct_step
    import hmsct_pkg::*;
(
    input  timer_state_t  state,
    input  timer_cfg_t    cfg,
    input  logic [2:0]    operation,
    input  logic [1:0]    field_select,
    output timer_state_t  state_next,
    output timer_result_t result
);

    logic [16:0] elapsed_sum;
    logic        second_done;
    logic [5:0]  slot;
    logic [5:0]  slot_top;
    logic [5:0]  slot_new;
    logic        slot_valid;
    logic        fin;

    assign elapsed_sum = state.elapsed_ms + {7'd0, cfg.tick_step_ms};
    assign second_done = elapsed_sum >= {1'b0, cfg.second_threshold_ms};

    always_comb
    begin
        slot       = 6'd0;
        slot_valid = 1'b1;
        case (field_select)
            SEL_HOURS:   slot = {1'b0, state.preset_hours};
            SEL_MINUTES: slot = state.preset_minutes;
            SEL_SECONDS: slot = state.preset_seconds;
            default:     slot_valid = 1'b0;
        endcase
    end

    assign slot_top = (field_select == SEL_HOURS) ? HOUR_MAX : MINSEC_MAX;

    always_comb
    begin
        state_next = state;
        fin        = 1'b0;
        slot_new   = slot;
        case (operation)
            OP_TICK:
            begin
                if (state.run_flag)
                begin
                    state_next.elapsed_ms = elapsed_sum;
                    if (second_done)
                    begin
                        state_next.elapsed_ms = 17'd0;
                        // borrow down through seconds, minutes, hours
                        if (state.cur_seconds != 6'd0)
                        begin
                            state_next.cur_seconds = state.cur_seconds - 6'd1;
                        end
                        else if (state.cur_minutes != 6'd0)
                        begin
                            state_next.cur_minutes = state.cur_minutes - 6'd1;
                            state_next.cur_seconds = MINSEC_MAX;
                        end
                        else if (state.cur_hours != 5'd0)
                        begin
                            state_next.cur_hours   = state.cur_hours - 5'd1;
                            state_next.cur_minutes = MINSEC_MAX;
                            state_next.cur_seconds = MINSEC_MAX;
                        end
                        else
                        begin
                            state_next.run_flag = 1'b0;
                            fin                 = 1'b1;
                        end
                    end
                end
            end
            OP_TOGGLE: state_next.run_flag = ~state.run_flag;
            OP_RAISE:  slot_new = (slot >= slot_top) ? 6'd0 : slot + 6'd1;
            OP_LOWER:  slot_new = (slot != 6'd0) ? slot - 6'd1 : slot;
            OP_COMMIT:
            begin
                state_next.cur_hours   = state.preset_hours;
                state_next.cur_minutes = state.preset_minutes;
                state_next.cur_seconds = state.preset_seconds;
                state_next.run_flag    = 1'b0;
            end
            default: ;
        endcase

        // write back the adjusted preset field
        case (field_select)
            SEL_HOURS:   state_next.preset_hours   = slot_new[4:0];
            SEL_MINUTES: state_next.preset_minutes = slot_new;
            SEL_SECONDS: state_next.preset_seconds = slot_new;
            default: ;
        endcase
    end

    assign result.count_hours   = state_next.cur_hours;
    assign result.count_minutes = state_next.cur_minutes;
    assign result.count_seconds = state_next.cur_seconds;
    assign result.is_running    = state_next.run_flag;
    assign result.finished      = fin;
    assign result.preset_value  = slot_valid ? slot_new : 6'd0;

endmodule

/* sv/hmsct_checker.sv */
// hmsct_checker: port-level assertions for the countdown timer, plus its bind.
// Depends on hms_countdown_timer and its channel interfaces.
module hmsct_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] count_hours,
    input logic [5:0] count_minutes,
    input logic [5:0] count_seconds,
    input logic       is_running,
    input logic       finished
);

    // A transfer in always yields a result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no result after command transfer");

    // A stalled result blocks new commands.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("command accepted while result stalled");

    // Finished means the countdown just stopped.
    a_finished_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |-> (!is_running && count_hours == 5'd0
            && count_minutes == 6'd0 && count_seconds == 6'd0))
        else $error("finished with running timer or nonzero count");

    // Count stays in clock range.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count_hours <= 5'd23 && count_minutes <= 6'd59
            && count_seconds <= 6'd59))
        else $error("count out of range");

    // Stalled result holds.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(count_hours)
            && $stable(count_minutes) && $stable(count_seconds)
            && $stable(finished)))
        else $error("stalled result changed");

endmodule

bind hms_countdown_timer hmsct_checker u_hmsct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .count_hours   (out_ch.count_hours),
    .count_minutes (out_ch.count_minutes),
    .count_seconds (out_ch.count_seconds),
    .is_running    (out_ch.is_running),
    .finished      (out_ch.finished)
);

/* dv/tb.sv */
// tb: self-checking testbench for the hh:mm:ss countdown timer.
// Depends on hmsct_pkg, hmsct_in_if, hmsct_out_if and hms_countdown_timer.
// Predicts every readout in-line and checks them in order on the result channel.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmsct_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hmsct_in_if  cmd_ch ();
    hmsct_out_if readout_ch ();

    hms_countdown_timer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (cmd_ch),
        .out_ch    (readout_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the timer: count, presets, accumulator and run flag,
    // plus the timing registers as last written.
    timer_state_t  timer_now;
    timer_cfg_t    timing_now;

    // Readouts predicted for accepted commands, oldest first.
    timer_result_t due_readouts[$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;
    int commands_sent   = 0;
    int bad_readouts    = 0;

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Timer prediction
    // ------------------------------------------------------------------

    // Current value of the selected preset field; the unused select reads 0.
    function automatic logic [5:0] preset_of(input logic [1:0] sel);
        case (sel)
            SEL_HOURS:   return 6'(timer_now.preset_hours);
            SEL_MINUTES: return timer_now.preset_minutes;
            SEL_SECONDS: return timer_now.preset_seconds;
            default:     return 6'd0;
        endcase
    endfunction

    function automatic void store_preset(input logic [1:0] sel, input logic [5:0] value);
        case (sel)
            SEL_HOURS:   timer_now.preset_hours   = value[4:0];
            SEL_MINUTES: timer_now.preset_minutes = value;
            SEL_SECONDS: timer_now.preset_seconds = value;
            default: ;
        endcase
    endfunction

    // Apply one command to the shadow timer and return the readout it causes.
    function automatic timer_result_t advance_timer(input logic [2:0] op,
                                                    input logic [1:0] sel);
        timer_result_t readout;
        logic [5:0]    top;
        logic [5:0]    field;
        logic          fin;
        fin   = 1'b0;
        top   = (sel == SEL_HOURS) ? HOUR_MAX : MINSEC_MAX;
        field = preset_of(sel);
        case (op)
            OP_TICK:
            begin
                // A stopped timer ignores ticks entirely.
                if (timer_now.run_flag)
                begin
                    timer_now.elapsed_ms = timer_now.elapsed_ms
                                         + 17'(timing_now.tick_step_ms);
                    if (timer_now.elapsed_ms >= 17'(timing_now.second_threshold_ms))
                    begin
                        timer_now.elapsed_ms = '0;
                        // Borrow down through seconds, minutes, hours.
                        if (timer_now.cur_seconds != 6'd0)
                            timer_now.cur_seconds = timer_now.cur_seconds - 6'd1;
                        else if (timer_now.cur_minutes != 6'd0)
                        begin
                            timer_now.cur_minutes = timer_now.cur_minutes - 6'd1;
                            timer_now.cur_seconds = MINSEC_MAX;
                        end
                        else if (timer_now.cur_hours != 5'd0)
                        begin
                            timer_now.cur_hours   = timer_now.cur_hours - 5'd1;
                            timer_now.cur_minutes = MINSEC_MAX;
                            timer_now.cur_seconds = MINSEC_MAX;
                        end
                        else
                        begin
                            // Second elapsed at 00:00:00: stop and flag it.
                            timer_now.run_flag = 1'b0;
                            fin                = 1'b1;
                        end
                    end
                end
            end
            OP_TOGGLE:
                timer_now.run_flag = !timer_now.run_flag;
            OP_RAISE:
                if (sel <= SEL_SECONDS)
                    store_preset(sel, (field >= top) ? 6'd0 : field + 6'd1);
            OP_LOWER:
                if (sel <= SEL_SECONDS && field != 6'd0)
                    store_preset(sel, field - 6'd1);
            OP_COMMIT:
            begin
                // Accumulator is left alone on commit.
                timer_now.cur_hours   = timer_now.preset_hours;
                timer_now.cur_minutes = timer_now.preset_minutes;
                timer_now.cur_seconds = timer_now.preset_seconds;
                timer_now.run_flag    = 1'b0;
            end
            default: ;
        endcase
        readout.count_hours   = timer_now.cur_hours;
        readout.count_minutes = timer_now.cur_minutes;
        readout.count_seconds = timer_now.cur_seconds;
        readout.is_running    = timer_now.run_flag;
        readout.finished      = fin;
        readout.preset_value  = preset_of(sel);
        return readout;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready generation and in-order checking
    // ------------------------------------------------------------------

    // Drive ready at the falling edge. A pending hold-off forces ready low
    // for that many cycles; otherwise stall at the current percentage.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles  = hold_off_cycles - 1;
            readout_ch.ready <= 1'b0;
        end
        else
            readout_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void check_field(input string name, input logic [5:0] want,
                                        input logic [5:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            bad_readouts++;
        end
    endfunction

    // Compare every readout transfer against the oldest prediction.
    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n === 1'b1 && readout_ch.valid === 1'b1 && readout_ch.ready === 1'b1)
        begin
            if (due_readouts.size() == 0)
            begin
                $error("readout transfer with no command outstanding");
                bad_readouts++;
            end
            else
            begin
                want = due_readouts.pop_front();
                check_field("count_hours",   6'(want.count_hours),  6'(readout_ch.count_hours));
                check_field("count_minutes", want.count_minutes,    readout_ch.count_minutes);
                check_field("count_seconds", want.count_seconds,    readout_ch.count_seconds);
                check_field("is_running",    6'(want.is_running),   6'(readout_ch.is_running));
                check_field("finished",      6'(want.finished),     6'(readout_ch.finished));
                check_field("preset_value",  want.preset_value,     readout_ch.preset_value);
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Offer one command, idling first at the sender's rate, and predict its
    // readout at the transfer edge. Valid is left high; the next call or
    // quiesce decides at the following falling edge.
    task automatic send_command(input logic [2:0] op, input logic [1:0] sel);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid        <= 1'b0;
            cmd_ch.operation    <= 3'($urandom_range(7));
            cmd_ch.field_select <= 2'($urandom_range(3));
            @(negedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.operation    <= op;
        cmd_ch.field_select <= sel;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        due_readouts.push_back(advance_timer(op, sel));
        if (op <= OP_COMMIT)
            commands_sent++;
    endtask

    // Any operation code, any select, including the unused ones.
    task automatic send_stray_command();
        send_command(3'($urandom_range(7)), 2'($urandom_range(3)));
    endtask

    // Drop valid and wait until every predicted readout has come back.
    task automatic quiesce();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (due_readouts.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Registers are only written with the block idle.
    task automatic write_register(input logic idx, input logic [CFG_DATA_W-1:0] data);
        quiesce();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_TICK_STEP)
            timing_now.tick_step_ms = data[9:0];
        else
            timing_now.second_threshold_ms = data;
    endtask

    task automatic set_timing(input int step_ms, input int threshold_ms);
        write_register(CFG_TICK_STEP, CFG_DATA_W'(step_ms));
        write_register(CFG_THRESHOLD, CFG_DATA_W'(threshold_ms));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Stopped tick, unused operation codes and the unused field select.
    task automatic test_idle_and_unused_codes();
        send_command(OP_TICK, SEL_HOURS);
        send_command(3'(OP_COMMIT + 3'd1), SEL_HOURS);
        send_command(3'(OP_COMMIT + 3'd2), 2'(SEL_SECONDS + 2'd1));
        send_command(3'(OP_COMMIT + 3'd3), SEL_SECONDS);
        send_command(OP_RAISE, 2'(SEL_SECONDS + 2'd1));
        send_command(OP_LOWER, 2'(SEL_SECONDS + 2'd1));
    endtask

    // Floor at zero, raise each field and lower the minutes, then commit 01:00:01.
    task automatic test_preset_editing();
        send_command(OP_LOWER, SEL_HOURS);
        send_command(OP_RAISE, SEL_HOURS);
        send_command(OP_RAISE, SEL_SECONDS);
        send_command(OP_RAISE, SEL_MINUTES);
        send_command(OP_LOWER, SEL_MINUTES);
        send_command(OP_COMMIT, SEL_MINUTES);
    endtask

    // One second per tick: borrow through hours, commit while running,
    // then start from 00:00:00 and see the finished pulse.
    task automatic test_countdown();
        set_timing(1000, 1000);
        send_command(OP_TOGGLE, SEL_HOURS);
        send_command(OP_TICK, SEL_SECONDS);
        send_command(OP_TICK, SEL_HOURS);
        send_command(OP_COMMIT, SEL_HOURS);
        send_command(OP_LOWER, SEL_HOURS);
        send_command(OP_LOWER, SEL_SECONDS);
        send_command(OP_COMMIT, SEL_SECONDS);
        send_command(OP_TOGGLE, SEL_MINUTES);
        send_command(OP_TICK, SEL_MINUTES);
    endtask

    // Zero threshold, a threshold shrunk below the accumulator, zero step.
    task automatic test_threshold_edges();
        set_timing(0, 0);
        send_command(OP_RAISE, SEL_SECONDS);
        send_command(OP_RAISE, SEL_SECONDS);
        send_command(OP_COMMIT, SEL_SECONDS);
        send_command(OP_TOGGLE, SEL_SECONDS);
        send_command(OP_TICK, SEL_SECONDS);
        set_timing(40, 1000);
        send_command(OP_TICK, SEL_SECONDS);
        send_command(OP_TICK, SEL_SECONDS);
        // Accumulator now sits above the new threshold.
        write_register(CFG_THRESHOLD, CFG_DATA_W'(50));
        send_command(OP_TICK, SEL_SECONDS);
        set_timing(0, 1000);
        send_command(OP_TICK, SEL_MINUTES);
    endtask

    // Hold the result side off for a long stretch while commands keep
    // coming, so the result register fills and the input stalls.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 80;
        repeat (40)
            send_command(3'($urandom_range(4)), 2'($urandom_range(3)));
        quiesce();
    endtask

    // One countdown session: maybe clear the presets, edit them, commit,
    // start, and tick with the odd stray command mixed in.
    task automatic run_session();
        int         reps;
        int         ticks;
        logic [1:0] sel;
        if ($urandom_range(2) == 0)
            for (int s = 0; s < 3; s++)
                while (preset_of(2'(s)) != 6'd0)
                    send_command(OP_LOWER, 2'(s));
        for (int s = 0; s < 3; s++)
        begin
            sel = 2'(s);
            // Long raise runs walk the field through its wrap.
            reps = ($urandom_range(11) == 0) ? $urandom_range(70, 24) : $urandom_range(3);
            for (int k = 0; k < reps; k++)
                send_command((reps > 3 || $urandom_range(1) == 1) ? OP_RAISE : OP_LOWER, sel);
        end
        if ($urandom_range(9) == 0)
            send_stray_command();
        send_command(OP_COMMIT, 2'($urandom_range(3)));
        send_command(OP_TOGGLE, 2'($urandom_range(3)));
        ticks = $urandom_range(40, 4);
        repeat (ticks)
        begin
            if ($urandom_range(11) == 0)
                send_stray_command();
            else
                send_command(OP_TICK, 2'($urandom_range(3)));
        end
    endtask

    // Random sessions across several timing settings and idling patterns.
    task automatic test_random_sessions();
        int step_ms[6]   = '{1000, 1, 1000, 40, 1, 500};
        int thresh_ms[6] = '{1000, 1, 1, 1000, 65535, 1500};
        int send_pct[6]  = '{0, 55, 0, 31, 31, 0};
        int recv_pct[6]  = '{0, 0, 55, 31, 31, 0};
        int budget[6]    = '{180, 180, 180, 180, 80, 180};
        int start;
        for (int p = 0; p < 6; p++)
        begin
            set_timing(step_ms[p], thresh_ms[p]);
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            start = commands_sent;
            while (commands_sent - start < budget[p])
                run_session();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        // Hold every input at a known value from time zero.
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_TICK_STEP;
        cfg_data              = '0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.operation      = OP_TICK;
        cmd_ch.field_select   = SEL_HOURS;
        readout_ch.ready      = 1'b0;
        timer_now             = '0;
        timing_now.tick_step_ms        = TICK_STEP_RST;
        timing_now.second_threshold_ms = THRESHOLD_RST;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_and_unused_codes();
        test_preset_editing();
        test_countdown();
        test_threshold_edges();
        test_backpressure();
        test_random_sessions();

        // Drain with a bound, then allow for the result register.
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        for (int c = 0; c < 2000 && due_readouts.size() != 0; c++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (due_readouts.size() != 0)
        begin
            $error("%0d readouts never arrived", due_readouts.size());
            bad_readouts++;
        end

        if (bad_readouts == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
sv/hmsct_pkg.sv
sv/hmsct_in_if.sv
sv/hmsct_out_if.sv
sv/hmsct_step.sv
sv/hms_countdown_timer.sv
sv/hmsct_checker.sv
dv/tb.sv
